/* hw/rtl/dual_wheel_speed_pi_core_assert.svh */
// Assertion macros used by the checker file of the dual wheel speed core.
`ifndef DUAL_WHEEL_SPEED_PI_CORE_ASSERT_SVH
`define DUAL_WHEEL_SPEED_PI_CORE_ASSERT_SVH

// Clocked on clk_i, masked while rst_ni is low.
`define DWSPI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dwspi assertion failed");

// Clocked on clk_i, also checked during reset.
`define DWSPI_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("dwspi reset assertion failed");

`endif

/* hw/rtl/dwspi_pkg.sv */
// Shared types and constants of the dual wheel speed PI core.
`default_nettype none

package dwspi_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TARGET_W        = 16;
  localparam int DRIVE_W         = 12;
  localparam int GAIN_W          = 8;
  localparam int ACC_W           = 32;
  localparam int HIST_DEPTH      = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int DRIVE_MAX       = 2047;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 8'd20;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 8'd10;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_RIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LEFT  = 3'd3;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
  } gains_t;

endpackage

`default_nettype wire

/* hw/rtl/dwspi_wheel.sv */
// One wheel: sample history, moving sum, incremental PI step and its state.
`default_nettype none

module dwspi_wheel import dwspi_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire gains_t                        gains_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic signed [TARGET_W-1:0]    target_i,
  output logic signed [DRIVE_W-1:0]          drive_o,
  output logic signed [SAMPLE_BITS+1:0]      sum_o
);

  localparam int SUM_W  = SAMPLE_BITS + 2;
  localparam int ERR_W  = ((SUM_W > TARGET_W) ? SUM_W : TARGET_W) + 1;
  localparam int KG_W   = GAIN_W + 2;
  localparam int PROD_W = ERR_W + KG_W;
  localparam int U_W    = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 2;

  localparam logic signed [U_W-1:0] ACC_HI = U_W'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [U_W-1:0] ACC_LO = -ACC_HI - U_W'(1);
  localparam logic signed [U_W-1:0] DRV_HI = U_W'(DRIVE_MAX);
  localparam logic signed [U_W-1:0] DRV_LO = -DRV_HI;

  logic signed [SAMPLE_BITS-1:0] hist_q [HIST_DEPTH];
  logic signed [ERR_W-1:0]       err_q, err_d;
  logic signed [ACC_W-1:0]       acc_q, acc_d;

  logic signed [SUM_W-1:0]  sum;
  logic signed [KG_W-1:0]   kpki, kp_s;
  logic signed [PROD_W-1:0] prod_new, prod_old;
  logic signed [U_W-1:0]    u;

  always_comb begin
    sum = SUM_W'(sample_i) + SUM_W'(hist_q[0]) + SUM_W'(hist_q[1]) + SUM_W'(hist_q[2]);
    err_d = ERR_W'(target_i) - ERR_W'(sum);
    kp_s = signed'({2'b00, gains_i.kp});
    kpki = signed'({2'b00, gains_i.kp}) + signed'({2'b00, gains_i.ki});
    prod_new = PROD_W'(kpki) * PROD_W'(err_d);
    prod_old = PROD_W'(kp_s) * PROD_W'(err_q);
    u = U_W'(prod_new) - U_W'(prod_old) + U_W'(acc_q);
    if (u > ACC_HI) begin
      acc_d = ACC_HI[ACC_W-1:0];
    end else if (u < ACC_LO) begin
      acc_d = ACC_LO[ACC_W-1:0];
    end else begin
      acc_d = u[ACC_W-1:0];
    end
    if (u > DRV_HI) begin
      drive_o = DRV_HI[DRIVE_W-1:0];
    end else if (u < DRV_LO) begin
      drive_o = DRV_LO[DRIVE_W-1:0];
    end else begin
      drive_o = u[DRIVE_W-1:0];
    end
    sum_o = sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      err_q <= '0;
      acc_q <= '0;
    end else if (step_i) begin
      hist_q[0] <= sample_i;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
      err_q <= err_d;
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dual_wheel_speed_pi_core.sv */
// Top level of the dual wheel speed PI core: gains, input and result registers.
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_stall_o   speed_*_i, target_*_i
//  out      source     out_valid_o / out_stall_i drive_*_o, speed_sum_*_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls; the result register drives the outputs.
// The input register feeds one pass of sum, error and PI arithmetic per wheel
// into the result register; wheel state advances as an item moves across.
// Reset loads the default gains and clears history, errors and accumulators.
// A stalled result holds; the input side stalls only when both registers are full.
`default_nettype none

module dual_wheel_speed_pi_core import dwspi_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] speed_right_i,
  input  wire logic signed [SAMPLE_BITS-1:0] speed_left_i,
  input  wire logic signed [TARGET_W-1:0]    target_right_i,
  input  wire logic signed [TARGET_W-1:0]    target_left_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [DRIVE_W-1:0]          drive_right_o,
  output logic signed [DRIVE_W-1:0]          drive_left_o,
  output logic signed [SAMPLE_BITS+1:0]      speed_sum_right_o,
  output logic signed [SAMPLE_BITS+1:0]      speed_sum_left_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [GAIN_W-1:0]             cfg_data_i
);

  gains_t gains_right_q, gains_left_q;

  logic                          in_valid_q, in_valid_d;
  logic signed [SAMPLE_BITS-1:0] spd_r_q, spd_l_q;
  logic signed [TARGET_W-1:0]    tgt_r_q, tgt_l_q;

  logic                          out_valid_q, out_valid_d;
  logic signed [DRIVE_W-1:0]     drv_r_q, drv_l_q;
  logic signed [SAMPLE_BITS+1:0] sum_r_q, sum_l_q;

  logic                          out_ready, step, in_acc;
  logic signed [DRIVE_W-1:0]     drv_r, drv_l;
  logic signed [SAMPLE_BITS+1:0] sum_r, sum_l;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && out_ready;
  assign in_stall_o  = in_valid_q && !out_ready;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_acc || (in_valid_q && !step);
  assign out_valid_d = out_ready ? in_valid_q : out_valid_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_right_q <= '{kp: PROP_GAIN_RST, ki: INTEG_GAIN_RST};
      gains_left_q  <= '{kp: PROP_GAIN_RST, ki: INTEG_GAIN_RST};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PROP_RIGHT:  gains_right_q.kp <= cfg_data_i;
        REG_INTEG_RIGHT: gains_right_q.ki <= cfg_data_i;
        REG_PROP_LEFT:   gains_left_q.kp  <= cfg_data_i;
        REG_INTEG_LEFT:  gains_left_q.ki  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      spd_r_q <= speed_right_i;
      spd_l_q <= speed_left_i;
      tgt_r_q <= target_right_i;
      tgt_l_q <= target_left_i;
    end
    if (step) begin
      drv_r_q <= drv_r;
      drv_l_q <= drv_l;
      sum_r_q <= sum_r;
      sum_l_q <= sum_l;
    end
  end

  dwspi_wheel #(.SAMPLE_BITS(SAMPLE_BITS)) u_wheel_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .gains_i  (gains_right_q),
    .sample_i (spd_r_q),
    .target_i (tgt_r_q),
    .drive_o  (drv_r),
    .sum_o    (sum_r)
  );

  dwspi_wheel #(.SAMPLE_BITS(SAMPLE_BITS)) u_wheel_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .gains_i  (gains_left_q),
    .sample_i (spd_l_q),
    .target_i (tgt_l_q),
    .drive_o  (drv_l),
    .sum_o    (sum_l)
  );

  assign out_valid_o       = out_valid_q;
  assign drive_right_o     = drv_r_q;
  assign drive_left_o      = drv_l_q;
  assign speed_sum_right_o = sum_r_q;
  assign speed_sum_left_o  = sum_l_q;

endmodule

`default_nettype wire

/* hw/rtl/dwspi_checker.sv */
// Port-level checks of the dual wheel speed PI core and their bind.
`default_nettype none

`include "dual_wheel_speed_pi_core_assert.svh"

module dwspi_checker import dwspi_pkg::*; (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic signed [DRIVE_W-1:0] drive_right_o,
  input wire logic signed [DRIVE_W-1:0] drive_left_o
);

  localparam logic signed [DRIVE_W-1:0] DRV_NEG_END = {1'b1, {(DRIVE_W-1){1'b0}}};

  `DWSPI_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `DWSPI_ASSERT(a_in_stall_blocked, in_stall_o |-> out_valid_o && out_stall_i)
  `DWSPI_ASSERT(a_drive_right_range, out_valid_o |-> drive_right_o != DRV_NEG_END)
  `DWSPI_ASSERT(a_drive_left_range, out_valid_o |-> drive_left_o != DRV_NEG_END)
  `DWSPI_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o && !in_stall_o)

endmodule

bind dual_wheel_speed_pi_core dwspi_checker u_dwspi_checker (.*);

`default_nettype wire

/* test/dwspi_result_check.sv */
`timescale 1ns / 100ps
// Checker for the dual wheel speed PI core: predicts every result item and compares it.
module dwspi_result_check import dwspi_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] speed_right_i,
  input  logic signed [SAMPLE_BITS-1:0] speed_left_i,
  input  logic signed [TARGET_W-1:0]    target_right_i,
  input  logic signed [TARGET_W-1:0]    target_left_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic signed [DRIVE_W-1:0]     drive_right_o,
  input  logic signed [DRIVE_W-1:0]     drive_left_o,
  input  logic signed [SAMPLE_BITS+1:0] speed_sum_right_o,
  input  logic signed [SAMPLE_BITS+1:0] speed_sum_left_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [GAIN_W-1:0]             cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int WHEELS = 2;
  localparam int RIGHT = 0;
  localparam int LEFT = 1;
  localparam int ERR_W = SAMPLE_BITS + 3;
  localparam int REPORT_MAX = 10;
  localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct {
    logic signed [DRIVE_W-1:0]     drive_right;
    logic signed [DRIVE_W-1:0]     drive_left;
    logic signed [SAMPLE_BITS+1:0] sum_right;
    logic signed [SAMPLE_BITS+1:0] sum_left;
  } wheel_result_t;

  gains_t                        gains [WHEELS];
  logic signed [SAMPLE_BITS-1:0] history [WHEELS][HIST_DEPTH];
  logic signed [ERR_W-1:0]       last_error [WHEELS];
  logic signed [ACC_W-1:0]       accum [WHEELS];
  wheel_result_t                 drive_expect_q [$];
  int                            failures;

  function automatic void advance_wheel(input int w,
                                        input logic signed [SAMPLE_BITS-1:0] sample,
                                        input logic signed [TARGET_W-1:0] target,
                                        output logic signed [SAMPLE_BITS+1:0] sum,
                                        output logic signed [DRIVE_W-1:0] drive);
    longint s, e, u, kp, ki, acc_next, drv;
    int k;
    s = longint'(sample);
    for (k = 0; k < HIST_DEPTH; k++) s += longint'(history[w][k]);
    kp = longint'(gains[w].kp);
    ki = longint'(gains[w].ki);
    e = longint'(target) - s;
    u = (kp + ki) * e - kp * longint'(last_error[w]) + longint'(accum[w]);
    for (k = HIST_DEPTH - 1; k > 0; k--) history[w][k] = history[w][k-1];
    history[w][0] = sample;
    last_error[w] = e[ERR_W-1:0];
    if (u > ACC_HI) acc_next = ACC_HI;
    else if (u < ACC_LO) acc_next = ACC_LO;
    else acc_next = u;
    accum[w] = acc_next[ACC_W-1:0];
    if (u > DRIVE_MAX) drv = DRIVE_MAX;
    else if (u < -DRIVE_MAX) drv = -DRIVE_MAX;
    else drv = u;
    sum = s[SAMPLE_BITS+1:0];
    drive = drv[DRIVE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    wheel_result_t got, want, predicted;
    int w, k;
    if (!rst_ni) begin
      for (w = 0; w < WHEELS; w++) begin
        gains[w].kp = PROP_GAIN_RST;
        gains[w].ki = INTEG_GAIN_RST;
        for (k = 0; k < HIST_DEPTH; k++) history[w][k] = '0;
        last_error[w] = '0;
        accum[w] = '0;
      end
      drive_expect_q.delete();
      failures = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.drive_right = drive_right_o;
        got.drive_left = drive_left_o;
        got.sum_right = speed_sum_right_o;
        got.sum_left = speed_sum_left_o;
        if (drive_expect_q.size() == 0) begin
          if (failures < REPORT_MAX)
            $display("%0t: unexpected result item drive R %0d L %0d sum R %0d L %0d",
                     $time, got.drive_right, got.drive_left, got.sum_right, got.sum_left);
          failures++;
        end else begin
          want = drive_expect_q.pop_front();
          if (got.drive_right !== want.drive_right || got.drive_left !== want.drive_left ||
              got.sum_right !== want.sum_right || got.sum_left !== want.sum_left) begin
            if (failures < REPORT_MAX) begin
              $display("%0t: mismatch expected drive R %0d L %0d sum R %0d L %0d",
                       $time, want.drive_right, want.drive_left, want.sum_right,
                       want.sum_left);
              $display("%0t: mismatch actual   drive R %0d L %0d sum R %0d L %0d",
                       $time, got.drive_right, got.drive_left, got.sum_right,
                       got.sum_left);
            end
            failures++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        advance_wheel(RIGHT, speed_right_i, target_right_i, predicted.sum_right,
                      predicted.drive_right);
        advance_wheel(LEFT, speed_left_i, target_left_i, predicted.sum_left,
                      predicted.drive_left);
        drive_expect_q.push_back(predicted);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_PROP_RIGHT:  gains[RIGHT].kp = cfg_data_i;
          REG_INTEG_RIGHT: gains[RIGHT].ki = cfg_data_i;
          REG_PROP_LEFT:   gains[LEFT].kp = cfg_data_i;
          REG_INTEG_LEFT:  gains[LEFT].ki = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o <= failures;
      pending_o <= drive_expect_q.size();
    end
  end

endmodule

/* test/dual_wheel_speed_pi_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the dual wheel speed PI core: stimulus, gain phases, idling and verdict.
module dual_wheel_speed_pi_core_tb;
  import dwspi_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 135;

  localparam logic signed [SW-1:0]       S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]       S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [TARGET_W-1:0] T_MAX = {1'b0, {(TARGET_W-1){1'b1}}};
  localparam logic signed [TARGET_W-1:0] T_MIN = {1'b1, {(TARGET_W-1){1'b0}}};
  localparam logic [15:0]                PAT_A = 16'h5555;
  localparam logic [15:0]                PAT_B = 16'hAAAA;
  localparam logic [GAIN_W-1:0]          GAIN_MAX = '1;
  localparam logic [GAIN_W-1:0]          GAIN_ZERO = '0;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;
  typedef enum int {SHAPE_TRACK, SHAPE_WINDUP, SHAPE_NOISE} shape_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [SW-1:0]   speed_right_i = '0;
  logic signed [SW-1:0]   speed_left_i = '0;
  logic signed [TARGET_W-1:0] target_right_i = '0;
  logic signed [TARGET_W-1:0] target_left_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [DRIVE_W-1:0] drive_right_o;
  logic signed [DRIVE_W-1:0] drive_left_o;
  logic signed [SW+1:0]   speed_sum_right_o;
  logic signed [SW+1:0]   speed_sum_left_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [GAIN_W-1:0]      cfg_data_i = '0;

  int          check_failures;
  int          results_outstanding;
  int          burst_left = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  always #4 clk_i = ~clk_i;

  dual_wheel_speed_pi_core #(.SAMPLE_BITS(SW)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .speed_right_i(speed_right_i), .speed_left_i(speed_left_i),
    .target_right_i(target_right_i), .target_left_i(target_left_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .drive_right_o(drive_right_o), .drive_left_o(drive_left_o),
    .speed_sum_right_o(speed_sum_right_o), .speed_sum_left_o(speed_sum_left_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  dwspi_result_check #(.SAMPLE_BITS(SW)) u_check (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .speed_right_i(speed_right_i), .speed_left_i(speed_left_i),
    .target_right_i(target_right_i), .target_left_i(target_left_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .drive_right_o(drive_right_o), .drive_left_o(drive_left_o),
    .speed_sum_right_o(speed_sum_right_o), .speed_sum_left_o(speed_sum_left_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .fail_count_o(check_failures), .pending_o(results_outstanding)
  );

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= stall_left[1];
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic signed [SW-1:0] sr, input logic signed [SW-1:0] sl,
                           input logic signed [TARGET_W-1:0] tr,
                           input logic signed [TARGET_W-1:0] tl);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    speed_right_i <= sr;
    speed_left_i <= sl;
    target_right_i <= tr;
    target_left_i <= tl;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_gains(input gains_t right, input gains_t left);
    write_reg(REG_PROP_RIGHT, right.kp);
    write_reg(REG_INTEG_RIGHT, right.ki);
    write_reg(REG_PROP_LEFT, left.kp);
    write_reg(REG_INTEG_LEFT, left.ki);
    write_reg(CFG_IDX_W'($urandom_range(REG_INTEG_LEFT + 1, 2**CFG_IDX_W - 1)),
              GAIN_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_run();
    shape_e                    shape;
    int                        len, n, jitter, pick;
    bit                        up_r, up_l;
    logic signed [TARGET_W-1:0] tr, tl;
    logic signed [SW-1:0]      sr, sl;
    pick = $urandom_range(0, 7);
    shape = (pick < 4) ? SHAPE_TRACK : ((pick < 6) ? SHAPE_WINDUP : SHAPE_NOISE);
    case (shape)
      SHAPE_TRACK: begin
        len = $urandom_range(10, 40);
        tr = TARGET_W'(int'($urandom_range(0, 4000)) - 2000);
        tl = TARGET_W'(int'($urandom_range(0, 4000)) - 2000);
        for (n = 0; n < len; n++) begin
          if ($urandom_range(0, 7) == 0) tr = TARGET_W'(int'($urandom_range(0, 4000)) - 2000);
          if ($urandom_range(0, 7) == 0) tl = TARGET_W'(int'($urandom_range(0, 4000)) - 2000);
          jitter = $urandom_range(0, 6);
          jitter -= 3;
          sr = SW'(tr / 4 + jitter);
          jitter = $urandom_range(0, 6);
          jitter -= 3;
          sl = SW'(tl / 4 + jitter);
          send_item(sr, sl, tr, tl);
        end
      end
      SHAPE_WINDUP: begin
        len = $urandom_range(60, 120);
        up_r = 1'($urandom_range(0, 1));
        up_l = 1'($urandom_range(0, 1));
        for (n = 0; n < len; n++) begin
          sr = (up_r ? S_MIN : S_MAX) ^ SW'($urandom_range(0, 255));
          sl = (up_l ? S_MIN : S_MAX) ^ SW'($urandom_range(0, 255));
          send_item(sr, sl, up_r ? T_MAX : T_MIN, up_l ? T_MAX : T_MIN);
        end
      end
      default: begin
        len = $urandom_range(5, 20);
        for (n = 0; n < len; n++)
          send_item(SW'($urandom), SW'($urandom), TARGET_W'($urandom), TARGET_W'($urandom));
      end
    endcase
  endtask

  initial begin
    gains_t gr, gl;
    int     p, stop_at;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item('0, '0, '0, '0);
    repeat (4) send_item(S_MAX, S_MAX, T_MAX, T_MAX);
    repeat (4) send_item(S_MIN, S_MIN, T_MIN, T_MIN);
    repeat (3) send_item(S_MIN, S_MAX, T_MAX, T_MIN);
    repeat (3) send_item(S_MAX, S_MIN, T_MIN, T_MAX);
    send_item(SW'(PAT_A), SW'(PAT_B), PAT_B, PAT_A);
    send_item(SW'(PAT_B), SW'(PAT_A), PAT_A, PAT_B);
    repeat (3) send_item('0, '0, '0, '0);
    drain_results();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          gr = '{kp: GAIN_ZERO, ki: GAIN_ZERO};
          gl = gr;
        end
        1: begin
          gr = '{kp: GAIN_MAX, ki: GAIN_MAX};
          gl = gr;
        end
        2: begin
          gr = '{kp: GAIN_MAX, ki: GAIN_ZERO};
          gl = '{kp: GAIN_ZERO, ki: GAIN_MAX};
        end
        3: begin
          gr = '{kp: GAIN_ZERO, ki: GAIN_MAX};
          gl = '{kp: GAIN_MAX, ki: GAIN_ZERO};
        end
        4: begin
          gr = '{kp: PROP_GAIN_RST, ki: INTEG_GAIN_RST};
          gl = gr;
        end
        5: begin
          gr = '{kp: GAIN_W'($urandom_range(0, 3)), ki: GAIN_W'($urandom_range(0, 3))};
          gl = '{kp: GAIN_MAX, ki: GAIN_MAX};
        end
        default: begin
          gr = '{kp: GAIN_W'($urandom), ki: GAIN_W'($urandom)};
          gl = '{kp: GAIN_W'($urandom), ki: GAIN_W'($urandom)};
        end
      endcase
      load_gains(gr, gl);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) send_random_run();
      drain_results();
    end

    if (check_failures == 0 && results_outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
